// File: design/assert_macros.svh
// Assertion macros shared by the cache tag controller RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// File: design/sact_pkg.sv
// Package of the cache tag controller: item types, register map, constants.
// Depends on nothing; used by sact_policy and the core top level.
package sact_pkg;

   localparam int MAX_INDEX_BITS_DEF = 8;
   localparam int WAYS_DEF           = 4;
   localparam int TAG_W              = 30;
   localparam int STAMP_W            = 32;
   localparam int COST_W             = 18;
   localparam int WAY_OUT_W          = 2;
   localparam int CSR_ADDR_W         = 5;
   localparam int CSR_DATA_W         = 32;

   localparam logic KIND_STORE = 1'b1;

   localparam logic [COST_W-1:0] XFER_BASE      = 18'd100;
   localparam logic [COST_W-1:0] HIT_COST       = 18'd1;
   localparam logic [COST_W-1:0] WT_STORE_COST  = 18'd100;
   localparam logic [COST_W-1:0] WB_ALLOC_EXTRA = 18'd1;
   localparam logic [COST_W-1:0] WT_ALLOC_EXTRA = 18'd101;

   localparam logic [3:0] OFFSET_MIN = 4'd2;
   localparam logic [3:0] OFFSET_MAX = 4'd12;

   localparam logic [3:0] RST_OFFSET_BITS = 4'd4;
   localparam logic [3:0] RST_INDEX_BITS  = 4'd8;
   localparam logic [2:0] RST_WAYS_IN_USE = 3'd4;

   typedef enum logic [2:0] {
      REG_OFFSET_BITS       = 3'd0,
      REG_INDEX_BITS        = 3'd1,
      REG_WAYS_IN_USE       = 3'd2,
      REG_EVICTION_FIFO     = 3'd3,
      REG_COPY_BACK         = 3'd4,
      REG_NO_WRITE_ALLOCATE = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } state_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic                 allocated;
      logic                 victim_written_back;
      logic [COST_W-1:0]    cycle_cost;
   } rsp_type;

   typedef struct packed {
      logic [3:0] offset_bits;
      logic [3:0] index_bits;
      logic [2:0] ways_in_use;
      logic       eviction_fifo;
      logic       copy_back;
      logic       no_write_allocate;
   } cfg_type;

   function automatic logic [3:0] clamp_offset(input logic [3:0] v);
      logic [3:0] r;
      if (v < OFFSET_MIN) begin
         r = OFFSET_MIN;
      end else if (v > OFFSET_MAX) begin
         r = OFFSET_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: design/set_assoc_cache_tag_controller_core.sv
// An accepted item's set row is read into rd_row_ff; in ST_LOOK the result and updated row
// are registered unless a held response stalls them. No new item is taken until the last one is
// committed, as the read and write-back of the set row share the single-ported tag memory.
// Reset: configuration takes its reset values, the access counter clears, and a
// clearing pass zeroes every one of the 2**MAX_INDEX_BITS rows (no item accepted).
// Depends on sact_pkg, sact_policy and assert_macros.svh.
module set_assoc_cache_tag_controller_core import sact_pkg::*; #(
   parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEF,
   parameter int WAYS           = WAYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SETS  = 1 << MAX_INDEX_BITS;
   localparam int SET_W = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef struct packed {
      logic [WAYS-1:0]              valid;
      logic [WAYS-1:0]              dirty;
      logic [WAYS-1:0][TAG_W-1:0]   tag;
      logic [WAYS-1:0][STAMP_W-1:0] fill_stamp;
      logic [WAYS-1:0][STAMP_W-1:0] use_stamp;
   } row_type;

   row_type            mem [SETS];
   row_type            rd_row_ff;
   row_type            new_row;
   row_type            wr_row;
   logic [SET_W-1:0]   wr_addr;

   state_type          state_ff, state_in;
   cfg_type            cfg_ff, cfg_in;
   logic [SET_W-1:0]   clr_ff, clr_in;
   logic [STAMP_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_new;
   logic               kind_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [SET_W-1:0]   set_ff;

   logic               accept;
   logic               commit;
   logic               clearing;
   logic               clr_last;
   logic               csr_write;
   reg_idx_type        csr_idx;

   logic [3:0]         ob;
   logic [4:0]         ib;
   logic [5:0]         tag_shift;
   logic [31:0]        set_mask;
   logic [31:0]        set_full;
   logic [31:0]        tag_full;
   logic [SET_W-1:0]   req_set;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx)
            REG_OFFSET_BITS:       cfg_in.offset_bits       = csr_pwdata[3:0];
            REG_INDEX_BITS:        cfg_in.index_bits        = csr_pwdata[3:0];
            REG_WAYS_IN_USE:       cfg_in.ways_in_use       = csr_pwdata[2:0];
            REG_EVICTION_FIFO:     cfg_in.eviction_fifo     = csr_pwdata[0];
            REG_COPY_BACK:         cfg_in.copy_back         = csr_pwdata[0];
            REG_NO_WRITE_ALLOCATE: cfg_in.no_write_allocate = csr_pwdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         REG_OFFSET_BITS:       csr_prdata[3:0] = cfg_ff.offset_bits;
         REG_INDEX_BITS:        csr_prdata[3:0] = cfg_ff.index_bits;
         REG_WAYS_IN_USE:       csr_prdata[2:0] = cfg_ff.ways_in_use;
         REG_EVICTION_FIFO:     csr_prdata[0]   = cfg_ff.eviction_fifo;
         REG_COPY_BACK:         csr_prdata[0]   = cfg_ff.copy_back;
         REG_NO_WRITE_ALLOCATE: csr_prdata[0]   = cfg_ff.no_write_allocate;
         default:               csr_prdata      = '0;
      endcase
   end

   // ---------------- address split ----------------
   assign ob = clamp_offset(cfg_ff.offset_bits);

   always_comb begin
      if (int'(cfg_ff.index_bits) > MAX_INDEX_BITS) begin
         ib = 5'(MAX_INDEX_BITS);
      end else begin
         ib = {1'b0, cfg_ff.index_bits};
      end
   end

   assign tag_shift = {2'b00, ob} + {1'b0, ib};
   assign set_mask  = ~({32{1'b1}} << ib);
   assign set_full  = (req_item.address >> ob) & set_mask;
   assign tag_full  = req_item.address >> tag_shift;
   assign req_set   = set_full[SET_W-1:0];

   // ---------------- control ----------------
   assign clr_last = (clr_ff == SET_W'(SETS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_LOOK;
         ST_LOOK:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      clearing  = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clearing  = 1'b1;
         ST_IDLE:  req_ready = 1'b1;
         ST_LOOK:  commit    = !rsp_valid_ff || rsp_ready;
         default:  clearing  = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   assign clr_in       = clearing ? clr_ff + SET_W'(1) : clr_ff;
   assign count_in     = commit ? count_ff + STAMP_W'(1) : count_ff;
   assign rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{offset_bits: RST_OFFSET_BITS, index_bits: RST_INDEX_BITS,
                           ways_in_use: RST_WAYS_IN_USE, eviction_fifo: 1'b0,
                           copy_back: 1'b1, no_write_allocate: 1'b0};
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_item.kind;
         tag_ff  <= tag_full[TAG_W-1:0];
         set_ff  <= req_set;
      end
      if (commit) begin
         rsp_ff <= rsp_new;
      end
   end

   // ---------------- tag memory ----------------
   // The write of one item lands before the next item's read,
   // so back-to-back accesses to one set always see fresh data.
   assign wr_addr = clearing ? clr_ff : set_ff;
   assign wr_row  = clearing ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (clearing || commit) begin
         mem[wr_addr] <= wr_row;
      end
      if (accept) begin
         rd_row_ff <= mem[req_set];
      end
   end

   sact_policy #(
      .WAYS  (WAYS),
      .WAY_W (WAY_W)
   ) u_policy (
      .cfg     (cfg_ff),
      .kind    (kind_ff),
      .tag     (tag_ff),
      .now     (count_ff),
      .valid_q (rd_row_ff.valid),
      .dirty_q (rd_row_ff.dirty),
      .tag_q   (rd_row_ff.tag),
      .fill_q  (rd_row_ff.fill_stamp),
      .use_q   (rd_row_ff.use_stamp),
      .valid_d (new_row.valid),
      .dirty_d (new_row.dirty),
      .tag_d   (new_row.tag),
      .fill_d  (new_row.fill_stamp),
      .use_d   (new_row.use_stamp),
      .rsp     (rsp_new)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // ---------------- assertions ----------------
`include "assert_macros.svh"

   `ASSERT_NEXT(a_accept_to_look, clock, reset, accept, state_ff == ST_LOOK)
   `ASSERT_NEXT(a_count_on_commit, clock, reset, commit, count_ff == $past(count_ff) + 32'd1)
   `ASSERT_SAME(a_hit_no_alloc, clock, reset, rsp_valid_ff && rsp_ff.hit, !rsp_ff.allocated && !rsp_ff.victim_written_back)
   `ASSERT_SAME(a_wb_needs_alloc, clock, reset, rsp_valid_ff && rsp_ff.victim_written_back, rsp_ff.allocated)
   `ASSERT_SAME(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff && !req_ready)

endmodule

// File: design/sact_policy.sv
// Hit search, victim choice, cost and updated set row of one access.
// Depends on sact_pkg; instantiated by set_assoc_cache_tag_controller_core.
module sact_policy import sact_pkg::*; #(
   parameter int WAYS  = WAYS_DEF,
   parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  cfg_type                          cfg,
   input  logic                             kind,
   input  logic [TAG_W-1:0]                 tag,
   input  logic [STAMP_W-1:0]               now,
   input  logic [WAYS-1:0]                  valid_q,
   input  logic [WAYS-1:0]                  dirty_q,
   input  logic [WAYS-1:0][TAG_W-1:0]       tag_q,
   input  logic [WAYS-1:0][STAMP_W-1:0]     fill_q,
   input  logic [WAYS-1:0][STAMP_W-1:0]     use_q,
   output logic [WAYS-1:0]                  valid_d,
   output logic [WAYS-1:0]                  dirty_d,
   output logic [WAYS-1:0][TAG_W-1:0]       tag_d,
   output logic [WAYS-1:0][STAMP_W-1:0]     fill_d,
   output logic [WAYS-1:0][STAMP_W-1:0]     use_d,
   output rsp_type                          rsp
);

   localparam int NW_W = $clog2(WAYS + 1);

   logic [3:0]                  ob;
   logic [COST_W-1:0]           xfer;
   logic [NW_W-1:0]             nw;
   logic                        hit;
   logic [WAY_W-1:0]            hit_way;
   logic                        have_empty;
   logic [WAY_W-1:0]            empty_way;
   logic [WAY_W-1:0]            victim;
   logic [STAMP_W-1:0]          best;
   logic [WAYS-1:0][STAMP_W-1:0] stamps;
   logic [WAY_W+WAY_OUT_W-1:0]  way_ext;
   logic [WAY_W-1:0]            way_sel;

   assign ob   = clamp_offset(cfg.offset_bits);
   assign xfer = XFER_BASE << (ob - OFFSET_MIN);

   always_comb begin
      if (cfg.ways_in_use == 3'd0) begin
         nw = NW_W'(1);
      end else if (int'(cfg.ways_in_use) > WAYS) begin
         nw = NW_W'(WAYS);
      end else begin
         nw = NW_W'(cfg.ways_in_use);
      end
   end

   // The first valid match wins; the last invalid way seen is the highest one.
   always_comb begin
      hit        = 1'b0;
      hit_way    = '0;
      have_empty = 1'b0;
      empty_way  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (w < int'(nw)) begin
            if (!valid_q[w]) begin
               have_empty = 1'b1;
               empty_way  = WAY_W'(w);
            end else if (!hit && tag_q[w] == tag) begin
               hit     = 1'b1;
               hit_way = WAY_W'(w);
            end
         end
      end
   end

   // Oldest stamp among the ways in use; strict compare keeps the lowest way on ties.
   assign stamps = cfg.eviction_fifo ? fill_q : use_q;

   always_comb begin
      best   = stamps[0];
      victim = '0;
      for (int w = 1; w < WAYS; w++) begin
         if (w < int'(nw) && stamps[w] < best) begin
            best   = stamps[w];
            victim = WAY_W'(w);
         end
      end
   end

   always_comb begin
      valid_d = valid_q;
      dirty_d = dirty_q;
      tag_d   = tag_q;
      fill_d  = fill_q;
      use_d   = use_q;
      way_sel = '0;
      rsp     = '0;
      if (hit) begin
         way_sel         = hit_way;
         rsp.hit         = 1'b1;
         rsp.cycle_cost  = HIT_COST;
         use_d[hit_way]  = now;
         if (kind == KIND_STORE) begin
            if (cfg.copy_back) begin
               dirty_d[hit_way] = 1'b1;
            end else begin
               rsp.cycle_cost = HIT_COST + WT_STORE_COST;
            end
         end
      end else if (kind == KIND_STORE && cfg.no_write_allocate) begin
         rsp.cycle_cost = WT_STORE_COST;
      end else begin
         way_sel        = have_empty ? empty_way : victim;
         rsp.allocated  = 1'b1;
         rsp.cycle_cost = xfer;
         if (!have_empty && dirty_q[victim]) begin
            rsp.victim_written_back = 1'b1;
            rsp.cycle_cost          = xfer + xfer;
         end
         valid_d[way_sel] = 1'b1;
         tag_d[way_sel]   = tag;
         fill_d[way_sel]  = now;
         use_d[way_sel]   = now;
         dirty_d[way_sel] = 1'b0;
         if (kind == KIND_STORE) begin
            if (cfg.copy_back) begin
               dirty_d[way_sel] = 1'b1;
               rsp.cycle_cost   = rsp.cycle_cost + WB_ALLOC_EXTRA;
            end else begin
               rsp.cycle_cost   = rsp.cycle_cost + WT_ALLOC_EXTRA;
            end
         end
      end
      way_ext = {{WAY_OUT_W{1'b0}}, way_sel};
      rsp.way = way_ext[WAY_OUT_W-1:0];
   end

endmodule
